@@ src/lwms_pkg.sv @@
// Shared types, codes and defaults for the lattice walker move step block.
package lwms_pkg;

  // Default geometry and table size
  localparam int LATTICE_WIDTH  = 256;
  localparam int LATTICE_HEIGHT = 256;
  localparam int PARTICLES      = 16384;

  // Fixed field widths
  localparam int PIN_W  = 14;
  localparam int UNW_W  = 24;
  localparam int CFG_W  = 17;

  // Request modes
  localparam logic [1:0] MODE_CELL  = 2'd0;
  localparam logic [1:0] MODE_PLACE = 2'd1;
  localparam logic [1:0] MODE_MOVE  = 2'd2;

  // Cell kinds
  localparam logic [2:0] KIND_EMPTY     = 3'd0;
  localparam logic [2:0] KIND_OBSTACLE  = 3'd1;
  localparam logic [2:0] KIND_ENZYME    = 3'd2;
  localparam logic [2:0] KIND_SUBSTRATE = 3'd3;
  localparam logic [2:0] KIND_PRODUCT   = 3'd4;

  // Move directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Outcome codes
  localparam logic [2:0] OUTCOME_DWELLING = 3'd0;
  localparam logic [2:0] OUTCOME_REACTED  = 3'd1;
  localparam logic [2:0] OUTCOME_MOVED    = 3'd2;
  localparam logic [2:0] OUTCOME_DWELL_GO = 3'd3;
  localparam logic [2:0] OUTCOME_BLOCKED  = 3'd4;
  localparam logic [2:0] OUTCOME_LOADED   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_RESIDENCE = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  // Configuration reset values
  localparam logic [15:0]      RESIDENCE_RST = 16'd0;
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 17'h10000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] particle;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [2:0]  cell_kind;
    logic [1:0]  direction;
    logic [15:0] reaction_draw;
    logic [23:0] current_time;
  } req_t;

  typedef struct packed {
    logic [13:0]        particle_out;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic signed [23:0] unwrapped_x;
    logic signed [23:0] unwrapped_y;
    logic               is_product;
    logic [2:0]         outcome;
    logic [23:0]        jump_count;
    logic [14:0]        product_total;
    logic [23:0]        birth_time;
    logic [7:0]         enzyme_x;
    logic [7:0]         enzyme_y;
  } rsp_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic red_step;
    logic fetch;
    logic look;
    logic decide;
    logic second;
    logic load;
    logic rsp_load;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic clr_last;
    logic need_red;
    logic red_last;
    logic in_move;
    logic is_move;
    logic dwelling;
    logic moved;
  } sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH,
    ST_LOOK,
    ST_DECIDE,
    ST_SECOND,
    ST_LOAD,
    ST_RESP
  } state_e;

endpackage

@@ src/lwms_ctrl.sv @@
// Sequencing state machine for the lattice walker move step block.
module lwms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  lwms_pkg::sts_t sts_i,
  output lwms_pkg::cmd_t cmd_o
);

  lwms_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwms_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      lwms_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = lwms_pkg::ST_IDLE;
        end
      end
      lwms_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_red) begin
            state_d = lwms_pkg::ST_REDUCE;
          end else if (sts_i.in_move) begin
            state_d = lwms_pkg::ST_FETCH;
          end else begin
            state_d = lwms_pkg::ST_LOAD;
          end
        end
      end
      lwms_pkg::ST_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.red_last) begin
          state_d = sts_i.is_move ? lwms_pkg::ST_FETCH : lwms_pkg::ST_LOAD;
        end
      end
      lwms_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = lwms_pkg::ST_LOOK;
      end
      lwms_pkg::ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = sts_i.dwelling ? lwms_pkg::ST_RESP : lwms_pkg::ST_DECIDE;
      end
      lwms_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.moved ? lwms_pkg::ST_SECOND : lwms_pkg::ST_RESP;
      end
      lwms_pkg::ST_SECOND: begin
        cmd_o.second = 1'b1;
        state_d      = lwms_pkg::ST_RESP;
      end
      lwms_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = lwms_pkg::ST_RESP;
      end
      lwms_pkg::ST_RESP: begin
        // hold the result until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.rsp_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = lwms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lwms_pkg::ST_CLEAR;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/lwms_dpath.sv @@
// Datapath: lattice and walker memories, move evaluation and result register.
module lwms_dpath #(
  parameter int LatticeWidth  = lwms_pkg::LATTICE_WIDTH,
  parameter int LatticeHeight = lwms_pkg::LATTICE_HEIGHT,
  parameter int Particles     = lwms_pkg::PARTICLES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lwms_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  lwms_pkg::req_t                in_req_i,
  input  lwms_pkg::cmd_t                cmd_i,
  output lwms_pkg::sts_t                sts_o,
  output lwms_pkg::rsp_t                out_rsp_o
);

  // Largest k with Particles << k still inside the particle field range
  function automatic int red_top_f(int p);
    int k;
    k = 0;
    for (int i = 0; i < lwms_pkg::PIN_W; i++) begin
      if ((p << (i + 1)) < (1 << lwms_pkg::PIN_W)) begin
        k = i + 1;
      end
    end
    return k;
  endfunction

  localparam int XW       = $clog2(LatticeWidth);
  localparam int YW       = $clog2(LatticeHeight);
  localparam int AW       = XW + YW;
  localparam int Cells    = 2 ** AW;
  localparam int IdxW     = (Particles > 1) ? $clog2(Particles) : 1;
  localparam int PinW     = lwms_pkg::PIN_W;
  localparam bit IsPow2   = (Particles & (Particles - 1)) == 0;
  localparam bit NeedRed  = !IsPow2 && (Particles < (1 << PinW));
  localparam int KTop     = red_top_f(Particles);
  localparam int KW       = (KTop > 0) ? $clog2(KTop + 1) : 1;

  localparam logic signed [23:0] UnwMax = 24'sh7FFFFF;
  localparam logic signed [23:0] UnwMin = -24'sh800000;

  typedef struct packed {
    logic [XW-1:0]      x;
    logic [YW-1:0]      y;
    logic signed [23:0] ux;
    logic signed [23:0] uy;
    logic               prod;
    logic [15:0]        dwell;
    logic [23:0]        jumps;
    logic [XW-1:0]      ex;
    logic [YW-1:0]      ey;
    logic [23:0]        birth;
  } walker_t;

  // Configuration registers
  logic [15:0]               res_q;
  logic [lwms_pkg::CFG_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= lwms_pkg::RESIDENCE_RST;
      thr_q <= lwms_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lwms_pkg::CFG_RESIDENCE: res_q <= cfg_wdata_i[15:0];
        lwms_pkg::CFG_THRESHOLD: thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request register
  lwms_pkg::req_t req_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
    end
  end

  // Coordinate wrap tables over the 8-bit field range
  logic [XW-1:0] xmod_tab [256];
  logic [YW-1:0] ymod_tab [256];

  for (genvar v = 0; v < 256; v++) begin : g_mod_tab
    assign xmod_tab[v] = XW'(v % LatticeWidth);
    assign ymod_tab[v] = YW'(v % LatticeHeight);
  end

  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  assign cx = xmod_tab[req_q.cell_x];
  assign cy = ymod_tab[req_q.cell_y];

  // Particle index reduction
  logic [IdxW-1:0] pidx;
  logic            red_last;

  if (NeedRed) begin : g_red
    logic [PinW-1:0] red_q;
    logic [KW-1:0]   k_q;
    logic [PinW:0]   sub;

    assign sub = (PinW + 1)'(Particles) << k_q;

    // subtract one shifted multiple per cycle, highest first
    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        red_q <= in_req_i.particle;
        k_q   <= KW'(KTop);
      end else if (cmd_i.red_step) begin
        if ({1'b0, red_q} >= sub) begin
          red_q <= red_q - sub[PinW-1:0];
        end
        k_q <= k_q - KW'(1);
      end
    end

    assign red_last = (k_q == '0);
    assign pidx     = IdxW'(red_q);
  end else begin : g_nored
    assign red_last = 1'b1;
    assign pidx     = (Particles == 1) ? '0 : IdxW'(req_q.particle);
  end

  // Lattice clearing sweep counter
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Walker memory
  walker_t         wk_mem [Particles];
  walker_t         wk_rd_q;
  walker_t         wk_q;
  logic            wk_we;
  walker_t         wk_wdata;

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wk_mem[pidx] <= wk_wdata;
    end
    if (cmd_i.fetch) begin
      wk_rd_q <= wk_mem[pidx];
    end
  end

  // Neighbor of the fetched walker
  logic [XW-1:0] nbr_x, nbr_x_q;
  logic [YW-1:0] nbr_y, nbr_y_q;

  always_comb begin
    nbr_x = wk_rd_q.x;
    nbr_y = wk_rd_q.y;
    case (req_q.direction)
      lwms_pkg::DIR_UP:
        nbr_y = (wk_rd_q.y == '0) ? YW'(LatticeHeight - 1) : wk_rd_q.y - YW'(1);
      lwms_pkg::DIR_DOWN:
        nbr_y = (wk_rd_q.y == YW'(LatticeHeight - 1)) ? '0 : wk_rd_q.y + YW'(1);
      lwms_pkg::DIR_RIGHT:
        nbr_x = (wk_rd_q.x == XW'(LatticeWidth - 1)) ? '0 : wk_rd_q.x + XW'(1);
      lwms_pkg::DIR_LEFT:
        nbr_x = (wk_rd_q.x == '0) ? XW'(LatticeWidth - 1) : wk_rd_q.x - XW'(1);
      default: ;
    endcase
  end

  // Lattice memory
  logic [2:0]    lat_mem [Cells];
  logic [2:0]    lat_rd_q;
  logic          lat_we;
  logic [AW-1:0] lat_waddr;
  logic [2:0]    lat_wdata;

  always_ff @(posedge clk_i) begin
    if (lat_we) begin
      lat_mem[lat_waddr] <= lat_wdata;
    end
    if (cmd_i.look) begin
      lat_rd_q <= lat_mem[{nbr_y, nbr_x}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      nbr_x_q <= nbr_x;
      nbr_y_q <= nbr_y;
    end
  end

  // Move decision on the neighbor kind
  logic    dwelling;
  logic    react;
  logic    nbr_empty;
  logic    nbr_obst;
  walker_t wk_dec;
  walker_t wk_new;
  logic [2:0] outcome_new;

  assign dwelling  = wk_rd_q.dwell != '0;
  assign react     = !wk_q.prod && (lat_rd_q == lwms_pkg::KIND_ENZYME)
                     && ({1'b0, req_q.reaction_draw} < thr_q);
  assign nbr_empty = lat_rd_q == lwms_pkg::KIND_EMPTY;
  assign nbr_obst  = lat_rd_q == lwms_pkg::KIND_OBSTACLE;

  always_comb begin
    wk_dec       = wk_rd_q;
    wk_dec.dwell = wk_rd_q.dwell - 16'd1;
  end

  always_comb begin
    wk_new      = wk_q;
    outcome_new = lwms_pkg::OUTCOME_BLOCKED;
    if (react) begin
      wk_new.prod  = 1'b1;
      wk_new.ex    = nbr_x_q;
      wk_new.ey    = nbr_y_q;
      wk_new.birth = req_q.current_time;
      wk_new.jumps = '0;
      outcome_new  = lwms_pkg::OUTCOME_REACTED;
    end else if (nbr_empty) begin
      wk_new.x = nbr_x_q;
      wk_new.y = nbr_y_q;
      case (req_q.direction)
        lwms_pkg::DIR_UP:
          if (wk_q.uy != UnwMin) wk_new.uy = wk_q.uy - 24'sd1;
        lwms_pkg::DIR_DOWN:
          if (wk_q.uy != UnwMax) wk_new.uy = wk_q.uy + 24'sd1;
        lwms_pkg::DIR_RIGHT:
          if (wk_q.ux != UnwMax) wk_new.ux = wk_q.ux + 24'sd1;
        lwms_pkg::DIR_LEFT:
          if (wk_q.ux != UnwMin) wk_new.ux = wk_q.ux - 24'sd1;
        default: ;
      endcase
      if (wk_q.prod && (wk_q.jumps != '1)) begin
        wk_new.jumps = wk_q.jumps + 24'd1;
      end
      outcome_new = lwms_pkg::OUTCOME_MOVED;
    end else if (nbr_obst) begin
      wk_new.dwell = res_q;
      outcome_new  = lwms_pkg::OUTCOME_DWELL_GO;
    end
  end

  // Walker write port
  always_comb begin
    wk_we    = 1'b0;
    wk_wdata = wk_new;
    if (cmd_i.load && (req_q.mode == lwms_pkg::MODE_PLACE)) begin
      wk_we          = 1'b1;
      wk_wdata       = '0;
      wk_wdata.x     = cx;
      wk_wdata.y     = cy;
      wk_wdata.ux    = 24'(cx);
      wk_wdata.uy    = 24'(cy);
    end else if (cmd_i.look && dwelling) begin
      wk_we    = 1'b1;
      wk_wdata = wk_dec;
    end else if (cmd_i.decide) begin
      wk_we = 1'b1;
    end
  end

  // Lattice write port
  always_comb begin
    lat_we    = 1'b0;
    lat_waddr = {cy, cx};
    lat_wdata = req_q.cell_kind;
    if (cmd_i.clr) begin
      lat_we    = 1'b1;
      lat_waddr = clr_q;
      lat_wdata = lwms_pkg::KIND_EMPTY;
    end else if (cmd_i.load) begin
      if (req_q.mode == lwms_pkg::MODE_CELL) begin
        lat_we = 1'b1;
      end else if (req_q.mode == lwms_pkg::MODE_PLACE) begin
        lat_we    = 1'b1;
        lat_wdata = lwms_pkg::KIND_SUBSTRATE;
      end
    end else if (cmd_i.decide) begin
      lat_waddr = {wk_q.y, wk_q.x};
      if (react) begin
        lat_we    = 1'b1;
        lat_wdata = lwms_pkg::KIND_PRODUCT;
      end else if (nbr_empty) begin
        lat_we    = 1'b1;
        lat_wdata = lwms_pkg::KIND_EMPTY;
      end
    end else if (cmd_i.second) begin
      lat_we    = 1'b1;
      lat_waddr = {nbr_y_q, nbr_x_q};
      lat_wdata = wk_q.prod ? lwms_pkg::KIND_PRODUCT : lwms_pkg::KIND_SUBSTRATE;
    end
  end

  // Working walker copy and outcome
  logic [2:0] outcome_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      wk_q      <= dwelling ? wk_dec : wk_rd_q;
      outcome_q <= lwms_pkg::OUTCOME_DWELLING;
    end else if (cmd_i.decide) begin
      wk_q      <= wk_new;
      outcome_q <= outcome_new;
    end
  end

  // Product counter, saturating
  logic [14:0] prod_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_cnt_q <= '0;
    end else if (cmd_i.decide && react && (prod_cnt_q != '1)) begin
      prod_cnt_q <= prod_cnt_q + 15'd1;
    end
  end

  // Result assembly and output register
  lwms_pkg::rsp_t rsp;
  lwms_pkg::rsp_t out_rsp_q;

  always_comb begin
    rsp               = '0;
    rsp.particle_out  = req_q.particle;
    rsp.product_total = prod_cnt_q;
    if (req_q.mode == lwms_pkg::MODE_MOVE) begin
      rsp.pos_x       = 8'(wk_q.x);
      rsp.pos_y       = 8'(wk_q.y);
      rsp.unwrapped_x = wk_q.ux;
      rsp.unwrapped_y = wk_q.uy;
      rsp.is_product  = wk_q.prod;
      rsp.outcome     = outcome_q;
      rsp.jump_count  = wk_q.jumps;
      rsp.birth_time  = wk_q.birth;
      rsp.enzyme_x    = 8'(wk_q.ex);
      rsp.enzyme_y    = 8'(wk_q.ey);
    end else begin
      rsp.pos_x   = 8'(cx);
      rsp.pos_y   = 8'(cy);
      rsp.outcome = lwms_pkg::OUTCOME_LOADED;
      if (req_q.mode == lwms_pkg::MODE_PLACE) begin
        rsp.unwrapped_x = 24'(cx);
        rsp.unwrapped_y = 24'(cy);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_rsp_o = out_rsp_q;

  // Status to the controller
  assign sts_o.clr_last = &clr_q;
  assign sts_o.need_red = NeedRed;
  assign sts_o.red_last = red_last;
  assign sts_o.in_move  = in_req_i.mode == lwms_pkg::MODE_MOVE;
  assign sts_o.is_move  = req_q.mode == lwms_pkg::MODE_MOVE;
  assign sts_o.dwelling = dwelling;
  assign sts_o.moved    = !react && nbr_empty;

endmodule

@@ src/lattice_walker_move_step_top.sv @@
// Top level of the lattice walker move step block.
// Requests enter on the in channel (valid/ready) and carry a mode: write a
// lattice cell, place a substrate walker, or move a walker one step. Each
// request yields exactly one result on the out channel (valid/ready).
// Configuration (dwell length, reaction threshold) is to be written by the
// user through a plain write port while no request is in flight; the block
// itself does not enforce this. A cell write or a placement is loaded
// directly. The single-ported walker and lattice memories set the steps of
// a move: it reads the walker, then the neighbor cell, then writes the
// walker and, unless the walker is dwelling, up to two cells. A new request
// is taken the cycle after its result is registered, so the block finishes
// one request before it takes the next. When Particles is not a power of
// two and is below 2**14, the walker index is reduced one shifted subtract
// per cycle. After reset the lattice is swept to empty, one cell per cycle
// over all 2**(clog2(width)+clog2(height)) cells (65536 by default);
// in_ready_o stays low meanwhile. A result waiting on a stalled receiver
// sits in the output register, and the next request is still accepted
// behind it.
module lattice_walker_move_step_top #(
  parameter int LatticeWidth  = lwms_pkg::LATTICE_WIDTH,
  parameter int LatticeHeight = lwms_pkg::LATTICE_HEIGHT,
  parameter int Particles     = lwms_pkg::PARTICLES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [lwms_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lwms_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lwms_pkg::rsp_t             out_rsp_o
);

  lwms_pkg::cmd_t cmd;
  lwms_pkg::sts_t sts;

  // Sequencer
  lwms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memories and move evaluation
  lwms_dpath #(
    .LatticeWidth  (LatticeWidth),
    .LatticeHeight (LatticeHeight),
    .Particles     (Particles)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ test/lwms_move_checker.sv @@
// Result checker for the lattice walker move step block: predicts each result and compares it.
module lwms_move_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [lwms_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  lwms_pkg::req_t             in_req_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  lwms_pkg::rsp_t             out_rsp_i,
  output int                         err_count_o,
  output int                         pending_o
);

  localparam int UNW_MAX = 8388607;
  localparam int UNW_MIN = -8388608;
  localparam int CELLS   = lwms_pkg::LATTICE_WIDTH * lwms_pkg::LATTICE_HEIGHT;

  typedef struct packed {
    logic [7:0]         x;
    logic [7:0]         y;
    logic signed [23:0] ux;
    logic signed [23:0] uy;
    logic               prod;
    logic [15:0]        dwell;
    logic [23:0]        jumps;
    logic [7:0]         ex;
    logic [7:0]         ey;
    logic [23:0]        birth;
  } walker_rec_t;

  // Shadow copy of the block state and its registers
  logic [2:0]                 lattice_q [CELLS];
  walker_rec_t                walker_q [lwms_pkg::PARTICLES];
  logic [14:0]                product_count;
  logic [15:0]                residence_limit;
  logic [lwms_pkg::CFG_W-1:0] reaction_threshold;

  lwms_pkg::rsp_t expected_rsp_q [$];
  int             mismatch_count;
  int             pending_count;

  assign err_count_o = mismatch_count;
  assign pending_o   = pending_count;

  // Start from the reset state: empty lattice, zero counter, default registers
  initial begin
    for (int i = 0; i < CELLS; i++) lattice_q[i] = lwms_pkg::KIND_EMPTY;
    for (int i = 0; i < lwms_pkg::PARTICLES; i++) walker_q[i] = '0;
    product_count      = '0;
    residence_limit    = lwms_pkg::RESIDENCE_RST;
    reaction_threshold = lwms_pkg::THRESHOLD_RST;
    mismatch_count     = 0;
    pending_count      = 0;
  end

  // Add a step d to an unwrapped coordinate, clamping at the 24-bit signed range
  function automatic logic signed [23:0] sat_step(input logic signed [23:0] v, input int d);
    int s;
    s = int'(v) + d;
    if (s > UNW_MAX) s = UNW_MAX;
    else if (s < UNW_MIN) s = UNW_MIN;
    return s[23:0];
  endfunction

  // Apply one request to the shadow state and build the result it yields
  function automatic lwms_pkg::rsp_t step_walker(input lwms_pkg::req_t r);
    walker_rec_t    w;
    lwms_pkg::rsp_t res;
    logic [7:0]     nx;
    logic [7:0]     ny;
    logic [2:0]     nk;
    logic [2:0]     code;
    int             dx;
    int             dy;
    res  = '0;
    w    = walker_q[r.particle];
    code = lwms_pkg::OUTCOME_LOADED;
    dx   = 0;
    dy   = 0;
    if (r.mode == lwms_pkg::MODE_PLACE) begin
      w    = '0;
      w.x  = r.cell_x;
      w.y  = r.cell_y;
      w.ux = {16'd0, r.cell_x};
      w.uy = {16'd0, r.cell_y};
      lattice_q[{r.cell_y, r.cell_x}] = lwms_pkg::KIND_SUBSTRATE;
    end else if (r.mode == lwms_pkg::MODE_MOVE) begin
      if (w.dwell != '0) begin
        w.dwell = w.dwell - 16'd1;
        code    = lwms_pkg::OUTCOME_DWELLING;
      end else begin
        // Wrapped neighbor; 8-bit arithmetic wraps each axis of the 256-by-256 torus
        nx = w.x;
        ny = w.y;
        case (r.direction)
          lwms_pkg::DIR_UP: begin
            ny = w.y - 8'd1;
            dy = -1;
          end
          lwms_pkg::DIR_DOWN: begin
            ny = w.y + 8'd1;
            dy = 1;
          end
          lwms_pkg::DIR_RIGHT: begin
            nx = w.x + 8'd1;
            dx = 1;
          end
          default: begin
            nx = w.x - 8'd1;
            dx = -1;
          end
        endcase
        nk = lattice_q[{ny, nx}];
        if (!w.prod && nk == lwms_pkg::KIND_ENZYME &&
            {1'b0, r.reaction_draw} < reaction_threshold) begin
          if (product_count != '1) product_count = product_count + 15'd1;
          w.prod  = 1'b1;
          w.ex    = nx;
          w.ey    = ny;
          w.birth = r.current_time;
          w.jumps = '0;
          lattice_q[{w.y, w.x}] = lwms_pkg::KIND_PRODUCT;
          code = lwms_pkg::OUTCOME_REACTED;
        end else if (nk == lwms_pkg::KIND_EMPTY) begin
          lattice_q[{w.y, w.x}] = lwms_pkg::KIND_EMPTY;
          w.x = nx;
          w.y = ny;
          lattice_q[{ny, nx}] = w.prod ? lwms_pkg::KIND_PRODUCT : lwms_pkg::KIND_SUBSTRATE;
          w.ux = sat_step(w.ux, dx);
          w.uy = sat_step(w.uy, dy);
          if (w.prod && w.jumps != '1) w.jumps = w.jumps + 24'd1;
          code = lwms_pkg::OUTCOME_MOVED;
        end else if (nk == lwms_pkg::KIND_OBSTACLE) begin
          w.dwell = residence_limit;
          code    = lwms_pkg::OUTCOME_DWELL_GO;
        end else begin
          code = lwms_pkg::OUTCOME_BLOCKED;
        end
      end
    end

    if (r.mode == lwms_pkg::MODE_PLACE || r.mode == lwms_pkg::MODE_MOVE) begin
      walker_q[r.particle] = w;
      res.particle_out = r.particle;
      res.pos_x        = w.x;
      res.pos_y        = w.y;
      res.unwrapped_x  = w.ux;
      res.unwrapped_y  = w.uy;
      res.is_product   = w.prod;
      res.outcome      = code;
      res.jump_count   = w.jumps;
      res.birth_time   = w.birth;
      res.enzyme_x     = w.ex;
      res.enzyme_y     = w.ey;
    end else begin
      // Cell write stores the kind; the unused mode only reports
      if (r.mode == lwms_pkg::MODE_CELL) lattice_q[{r.cell_y, r.cell_x}] = r.cell_kind;
      res.particle_out = r.particle;
      res.pos_x        = r.cell_x;
      res.pos_y        = r.cell_y;
      res.outcome      = lwms_pkg::OUTCOME_LOADED;
    end
    res.product_total = product_count;
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Track register writes, compare results, queue predictions
  always @(posedge clk_i) begin : watch
    lwms_pkg::rsp_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == lwms_pkg::CFG_RESIDENCE) residence_limit = cfg_wdata_i[15:0];
        else reaction_threshold = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result for particle %0d with no request waiting", out_rsp_i.particle_out);
          mismatch_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("particle_out", want.particle_out, out_rsp_i.particle_out);
          check_field("pos_x", want.pos_x, out_rsp_i.pos_x);
          check_field("pos_y", want.pos_y, out_rsp_i.pos_y);
          check_field("unwrapped_x", want.unwrapped_x, out_rsp_i.unwrapped_x);
          check_field("unwrapped_y", want.unwrapped_y, out_rsp_i.unwrapped_y);
          check_field("is_product", want.is_product, out_rsp_i.is_product);
          check_field("outcome", want.outcome, out_rsp_i.outcome);
          check_field("jump_count", want.jump_count, out_rsp_i.jump_count);
          check_field("product_total", want.product_total, out_rsp_i.product_total);
          check_field("birth_time", want.birth_time, out_rsp_i.birth_time);
          check_field("enzyme_x", want.enzyme_x, out_rsp_i.enzyme_x);
          check_field("enzyme_y", want.enzyme_y, out_rsp_i.enzyme_y);
        end
      end
      if (in_valid_i && in_ready_i) expected_rsp_q.push_back(step_walker(in_req_i));
      pending_count = expected_rsp_q.size();
    end
  end

endmodule

@@ test/lattice_walker_move_step_top_tb.sv @@
// Testbench top for the lattice walker move step block: request stimulus and verdict.
module lattice_walker_move_step_top_tb;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 6;
  localparam int TIMEOUT_CYCLES   = 1_000_000;
  localparam int TAIL_CYCLES      = 16;
  localparam int N_PHASE          = 6;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int POOL_SIZE        = 12;
  localparam int PARTICLES        = lwms_pkg::PARTICLES;

  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Busy corner of the torus; it straddles the wrap on both axes
  localparam logic [7:0] WIN_X0 = 8'd252;
  localparam logic [7:0] WIN_Y0 = 8'd252;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic                       cfg_idx_i   = lwms_pkg::CFG_RESIDENCE;
  logic [lwms_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  lwms_pkg::req_t             in_req_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b1;
  lwms_pkg::rsp_t             out_rsp_o;

  int err_count;
  int pending_count;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int n_move       = 0;
  int n_cell       = 0;
  int n_place      = 0;
  int n_spare      = 0;

  bit          placed [PARTICLES];
  logic [13:0] walker_pool [POOL_SIZE];

  always #CLK_HALF clk_i = ~clk_i;

  lattice_walker_move_step_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  lwms_move_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_i  (out_rsp_o),
    .err_count_o(err_count),
    .pending_o  (pending_count)
  );

  // Stall the result channel at the current rate
  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);

  function automatic lwms_pkg::req_t make_req(input logic [1:0] mode, input logic [13:0] pidx,
                                              input logic [7:0] x, input logic [7:0] y,
                                              input logic [2:0] kind, input logic [1:0] dir,
                                              input logic [15:0] draw,
                                              input logic [23:0] ctime);
    lwms_pkg::req_t r;
    r.mode          = mode;
    r.particle      = pidx;
    r.cell_x        = x;
    r.cell_y        = y;
    r.cell_kind     = kind;
    r.direction     = dir;
    r.reaction_draw = draw;
    r.current_time  = ctime;
    return r;
  endfunction

  // Drive one request from a falling edge and hold it until accepted
  task automatic send_req(input lwms_pkg::req_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (r.mode)
      lwms_pkg::MODE_MOVE:  n_move++;
      lwms_pkg::MODE_CELL:  n_cell++;
      lwms_pkg::MODE_PLACE: begin
        n_place++;
        placed[r.particle] = 1'b1;
      end
      default:              n_spare++;
    endcase
  endtask

  // Drop valid and hold off until every predicted result has arrived
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [lwms_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random values cut to field width
  function automatic logic [23:0] rnd_time();
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic logic [7:0] rnd_coord();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] rnd_dir();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic logic [2:0] rnd_kind();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [13:0] rnd_pidx();
    return 14'($urandom_range(0, PARTICLES - 1));
  endfunction

  // Mostly moves of placed walkers inside the busy corner, plus loads and noise
  task automatic send_random();
    int          pick;
    int          k;
    logic [13:0] pidx;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [2:0]  kind;
    logic [15:0] draw;
    pick = $urandom_range(0, 99);
    pidx = walker_pool[$urandom_range(0, POOL_SIZE - 1)];
    x    = WIN_X0 + 8'($urandom_range(0, 7));
    y    = WIN_Y0 + 8'($urandom_range(0, 7));
    draw = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                       : 16'($urandom_range(0, 65535));
    if (pick < 60 && placed[pidx]) begin
      send_req(make_req(lwms_pkg::MODE_MOVE, pidx, rnd_coord(), rnd_coord(),
                        rnd_kind(), rnd_dir(), draw, rnd_time()));
    end else if (pick < 72) begin
      // Place, now and then an index outside the pool that is never moved
      if ($urandom_range(0, 15) == 0) pidx = rnd_pidx();
      send_req(make_req(lwms_pkg::MODE_PLACE, pidx, x, y, rnd_kind(), rnd_dir(),
                        draw, rnd_time()));
    end else if (pick < 97) begin
      k = $urandom_range(0, 99);
      if (k < 35) kind = lwms_pkg::KIND_EMPTY;
      else if (k < 55) kind = lwms_pkg::KIND_OBSTACLE;
      else if (k < 80) kind = lwms_pkg::KIND_ENZYME;
      else if (k < 88) kind = lwms_pkg::KIND_SUBSTRATE;
      else if (k < 94) kind = lwms_pkg::KIND_PRODUCT;
      else kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      if ($urandom_range(0, 9) == 0) begin
        x = rnd_coord();
        y = rnd_coord();
      end
      send_req(make_req(lwms_pkg::MODE_CELL, rnd_pidx(), x, y, kind,
                        rnd_dir(), draw, rnd_time()));
    end else begin
      send_req(make_req(MODE_SPARE, rnd_pidx(), rnd_coord(), rnd_coord(), rnd_kind(),
                        rnd_dir(), 16'($urandom_range(0, 65535)), rnd_time()));
    end
  endtask

  // Stop a hung run
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int target;
    walker_pool[0] = 14'd0;
    walker_pool[1] = 14'h3FFF;
    walker_pool[2] = 14'd1;
    walker_pool[3] = 14'd2;
    walker_pool[4] = 14'd3;
    for (int i = 5; i < POOL_SIZE; i++) walker_pool[i] = rnd_pidx();

    // Hold reset, then release on a falling edge
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: dwell, reaction across the wrap, moves and blocking
    write_reg(lwms_pkg::CFG_RESIDENCE, 17'd2);
    write_reg(lwms_pkg::CFG_THRESHOLD, lwms_pkg::THRESHOLD_RST);
    send_req(make_req(lwms_pkg::MODE_PLACE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_PLACE, 14'h3FFF, 8'd255, 8'd255, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_CELL, 14'd0, 8'd0, 8'd255, lwms_pkg::KIND_OBSTACLE,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd1));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_DOWN, 16'd0, 24'd2));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_RIGHT, 16'd0, 24'd3));
    send_req(make_req(lwms_pkg::MODE_CELL, 14'd0, 8'd255, 8'd0, lwms_pkg::KIND_ENZYME,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_LEFT, 16'hFFFF, 24'hFFFFFF));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_LEFT, 16'd0, 24'd5));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_RIGHT, 16'd0, 24'd6));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_DOWN, 16'd0, 24'd7));
    send_req(make_req(lwms_pkg::MODE_CELL, 14'd0, 8'd2, 8'd1, KIND_SPARE_HI,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd0, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_RIGHT, 16'd0, 24'd8));
    send_req(make_req(MODE_SPARE, 14'h3FFF, 8'd255, 8'd255, KIND_SPARE_HI,
                      lwms_pkg::DIR_LEFT, 16'hFFFF, 24'hFFFFFF));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'h3FFF, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_DOWN, 16'd0, 24'd9));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'h3FFF, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd10));
    send_req(make_req(lwms_pkg::MODE_PLACE, 14'd1, 8'd10, 8'd10, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_PLACE, 14'd2, 8'd11, 8'd10, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd1, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_RIGHT, 16'd0, 24'd11));
    send_req(make_req(lwms_pkg::MODE_CELL, 14'd0, 8'd12, 8'd10, lwms_pkg::KIND_PRODUCT,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd2, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_RIGHT, 16'd0, 24'd12));

    // Directed: threshold edge and zero dwell length
    drain_results();
    write_reg(lwms_pkg::CFG_RESIDENCE, 17'd0);
    write_reg(lwms_pkg::CFG_THRESHOLD, 17'd1);
    send_req(make_req(lwms_pkg::MODE_PLACE, 14'd3, 8'd20, 8'd20, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_CELL, 14'd0, 8'd21, 8'd20, lwms_pkg::KIND_ENZYME,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd3, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_RIGHT, 16'd1, 24'd13));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd3, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_RIGHT, 16'd0, 24'd14));
    send_req(make_req(lwms_pkg::MODE_CELL, 14'd0, 8'd20, 8'd19, lwms_pkg::KIND_OBSTACLE,
                      lwms_pkg::DIR_UP, 16'd0, 24'd0));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd3, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd15));
    send_req(make_req(lwms_pkg::MODE_MOVE, 14'd3, 8'd0, 8'd0, lwms_pkg::KIND_EMPTY,
                      lwms_pkg::DIR_UP, 16'd0, 24'd16));

    // Random phases: a new register setting and idle pattern per phase
    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(lwms_pkg::CFG_RESIDENCE, 17'd3);
          write_reg(lwms_pkg::CFG_THRESHOLD, lwms_pkg::THRESHOLD_RST);
        end
        1: begin
          write_reg(lwms_pkg::CFG_RESIDENCE, 17'd0);
          write_reg(lwms_pkg::CFG_THRESHOLD, 17'd0);
        end
        2: begin
          write_reg(lwms_pkg::CFG_RESIDENCE, 17'd1);
          write_reg(lwms_pkg::CFG_THRESHOLD, 17'd32768);
        end
        3: begin
          write_reg(lwms_pkg::CFG_RESIDENCE, 17'd65535);
          write_reg(lwms_pkg::CFG_THRESHOLD, 17'd1);
        end
        4: begin
          write_reg(lwms_pkg::CFG_RESIDENCE, 17'd5);
          write_reg(lwms_pkg::CFG_THRESHOLD, 17'd40000);
        end
        default: begin
          write_reg(lwms_pkg::CFG_RESIDENCE, 17'd2);
          write_reg(lwms_pkg::CFG_THRESHOLD, 17'd65535);
        end
      endcase
      case (ph % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 82;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 82;
        end
        default: begin
          tx_idle_pct  = 15;
          rx_stall_pct = 15;
        end
      endcase
      target = n_move + n_cell + n_place + RANDOM_PER_PHASE;
      while (n_move + n_cell + n_place < target) begin
        // Now and then let the block run dry before the next request
        if ($urandom_range(0, 79) == 0) drain_results();
        send_random();
      end
    end

    // Let the last results come out, then a few quiet cycles
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d moves, %0d cell writes, %0d placements, %0d unused-mode requests",
             n_move, n_cell, n_place, n_spare);
    $display("across %0d register settings with sender gaps and receiver stalls in turn",
             N_PHASE + 2);
    if (err_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/lwms_pkg.sv
src/lwms_ctrl.sv
src/lwms_dpath.sv
src/lattice_walker_move_step_top.sv
test/lwms_move_checker.sv
test/lattice_walker_move_step_top_tb.sv
